FILE: design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Ring depth, pointer and count widths, command codes, status codes and the
// request bundle that drives the entry store.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;

  typedef enum logic [2:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_PUSH_TAIL = 3'd1,
    OP_POP_HEAD  = 3'd2,
    OP_POP_TAIL  = 3'd3,
    OP_SIZE      = 3'd4,
    OP_EMPTY     = 3'd5,
    OP_PEEK_HEAD = 3'd6,
    OP_PEEK_TAIL = 3'd7
  } opcode_t;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } deq_ram_req_t;

  function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] i);
    ring_next = (i == ADDR_W'(DEPTH - 1)) ? '0 : i + ADDR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] ring_prev(input logic [ADDR_W-1:0] i);
    ring_prev = (i == '0) ? ADDR_W'(DEPTH - 1) : i - ADDR_W'(1);
  endfunction

endpackage

FILE: design/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram: entry store of the double-ended queue
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module deq_ram (
  input  logic                          clk,
  input  deq_pkg::deq_ram_req_t         req,
  output logic [deq_pkg::DATA_W-1:0]    rd_data
);
  import deq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

FILE: design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed words in a ring store
// Commands arrive on the in_ channel (opcode, push_value); results leave on
// the out_ channel (result_value, status). Both use valid/ready.
// Pushes update the store and pointers in the accept cycle and give a beat
// only when the store is full (status full, value 0). Size, empty and any
// pop or peek on an empty queue answer from registers: the result beat is
// valid in the cycle after the command is accepted. A pop or peek on a
// non-empty queue reads the store (synchronous read), so its result passes
// through the store's read register and then the output register, and the
// block takes no new command in the cycle of the read.
// Throughput: one command per cycle for pushes, size and empty and for
// commands on an empty queue; a read of the store holds off the next command.
// The output register holds a result while the receiver stalls; a new
// command is taken only when that register is empty or being drained.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_opcode,
  input  logic signed [31:0]            in_push_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_result_value,
  output logic [1:0]                    out_status
);
  import deq_pkg::*;

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [ADDR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_value_r, out_value_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;

  deq_ram_req_t        ram_req;
  logic [DATA_W-1:0]   rd_data;
  logic                in_fire;
  logic                is_empty;
  logic                is_full;
  opcode_t             op;

  deq_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  assign op       = opcode_t'(in_opcode);
  assign is_empty = (occ_r == '0);
  assign is_full  = (occ_r == CNT_W'(DEPTH));
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    occ_nxt        = occ_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_req        = '0;
    ram_req.wr_data = in_push_value;

    if (state_r == S_READ) begin
      // store data has arrived: hand it to the output register
      state_nxt      = S_IDLE;
      out_valid_nxt  = 1'b1;
      out_value_nxt  = rd_data;
      out_status_nxt = ST_OK;
    end else if (in_fire) begin
      unique case (op)
        OP_PUSH_HEAD, OP_PUSH_TAIL: begin
          if (is_full) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = '0;
            out_status_nxt = ST_FULL;
          end else begin
            ram_req.wr_en = 1'b1;
            occ_nxt       = occ_r + CNT_W'(1);
            if (op == OP_PUSH_HEAD) begin
              head_nxt        = ring_prev(head_r);
              ram_req.wr_addr = ring_prev(head_r);
            end else begin
              tail_nxt        = ring_next(tail_r);
              ram_req.wr_addr = tail_r;
            end
          end
        end
        OP_SIZE: begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = DATA_W'(occ_r);
          out_status_nxt = ST_OK;
        end
        OP_EMPTY: begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = DATA_W'(is_empty);
          out_status_nxt = ST_OK;
        end
        OP_POP_HEAD, OP_POP_TAIL, OP_PEEK_HEAD, OP_PEEK_TAIL: begin
          if (is_empty) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = '1;
            out_status_nxt = ST_EMPTY;
          end else begin
            state_nxt     = S_READ;
            ram_req.rd_en = 1'b1;
            if (op == OP_POP_HEAD || op == OP_PEEK_HEAD) begin
              ram_req.rd_addr = head_r;
            end else begin
              ram_req.rd_addr = ring_prev(tail_r);
            end
            // pops advance the pointers now; the read address is already fixed
            if (op == OP_POP_HEAD) begin
              head_nxt = ring_next(head_r);
              occ_nxt  = occ_r - CNT_W'(1);
            end else if (op == OP_POP_TAIL) begin
              tail_nxt = ring_prev(tail_r);
              occ_nxt  = occ_r - CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = signed'(out_value_r);
  assign out_status       = out_status_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_read_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !out_valid_r)
    else $error("store read while output register busy");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != '0 && occ_r != CNT_W'(DEPTH)) |-> (head_r != tail_r))
    else $error("pointers meet with partial occupancy");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_full && (op == OP_PUSH_HEAD || op == OP_PUSH_TAIL))
      |=> (out_valid_r && out_status_r == ST_FULL && occ_r == CNT_W'(DEPTH)))
    else $error("push into full store not rejected");
`endif

endmodule
